>>> rtl/core/pstbl_pkg.sv
package pstbl_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int TOK_W = 34;
	localparam int PROD_W = 48;
	localparam logic [15:0] DEFAULT_WINDOW = 16'd1000;

	typedef enum logic [1:0] {
		REG_RATE     = 2'd0,
		REG_WINDOW   = 2'd1,
		REG_CAPACITY = 2'd2,
		REG_INTERVAL = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		OUT_CHARGED   = 2'd0,
		OUT_REJECTED  = 2'd1,
		OUT_UNTRACKED = 2'd2,
		OUT_BYPASS    = 2'd3
	} outcome_t;

	typedef struct packed {
		logic              valid;
		logic [31:0]       key;
		logic [TOK_W-1:0]  tokens;
		logic [31:0]       last;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clr_wr;
		logic addr_clr;
		logic addr_inc;
		logic addr_slot;
		logic rd;
		logic mul;
		logic scan_clr;
		logic sweep;
		logic scan_upd;
		logic charge_upd;
		logic insert;
		logic res_bypass;
		logic res_full;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic opcode;
		logic bypass;
		logic due;
		logic last;
		logic found;
		logic full;
	} sts_t;

endpackage

>>> rtl/core/pstbl_dp.sv
module pstbl_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pstbl_pkg::cmd_t                cmd,
	output pstbl_pkg::sts_t                sts,
	input  logic                           opcode,
	input  logic                           source_present,
	input  logic [31:0]                    source_key,
	input  logic [31:0]                    now_ms,
	input  logic [15:0]                    rate,
	input  logic [15:0]                    window,
	input  logic [16:0]                    capacity,
	input  logic [15:0]                    interval,
	output logic                           done,
	output logic                           reject,
	output logic [1:0]                     outcome,
	output logic [10:0]                    tracked_count
);

	pstbl_pkg::entry_t mem [pstbl_pkg::TABLE_ENTRIES];
	pstbl_pkg::entry_t rd_q;
	pstbl_pkg::entry_t wdata;
	logic wr;

	logic [pstbl_pkg::IDX_W-1:0] addr_q, slot_q, free_q;
	logic found_q, free_found_q, sweep_mode_q;
	logic [pstbl_pkg::CNT_W-1:0] count_q;
	logic [31:0] last_sweep_q, key_q, now_q;
	logic opcode_q, bypass_q;
	logic [pstbl_pkg::TOK_W-1:0] cap_q;
	logic [15:0] win_q;
	logic [pstbl_pkg::PROD_W-1:0] prod_q;
	logic gt_q;

	logic [pstbl_pkg::PROD_W:0] sum;
	logic [pstbl_pkg::TOK_W-1:0] rt;
	logic [31:0] new_last;
	logic freed, post_valid;
	logic [15:0] eff_win;

	assign eff_win = (window != 16'd0) ? window : pstbl_pkg::DEFAULT_WINDOW;

	// refill of the entry held in rd_q
	always_comb begin
		sum = {1'b0, prod_q} + {{(pstbl_pkg::PROD_W + 1 - pstbl_pkg::TOK_W){1'b0}}, rd_q.tokens};
		if (!gt_q) begin
			rt = rd_q.tokens;
		end else if (sum > {{(pstbl_pkg::PROD_W + 1 - pstbl_pkg::TOK_W){1'b0}}, cap_q}) begin
			rt = cap_q;
		end else begin
			rt = sum[pstbl_pkg::TOK_W-1:0];
		end
		new_last = gt_q ? now_q : rd_q.last;
		freed = sweep_mode_q && rd_q.valid && (rt >= cap_q);
		post_valid = rd_q.valid && !freed;
	end

	always_comb begin
		wr = 1'b0;
		wdata = rd_q;
		if (cmd.clr_wr) begin
			wr = 1'b1;
			wdata = '0;
		end else if (cmd.scan_upd && sweep_mode_q && rd_q.valid) begin
			wr = 1'b1;
			wdata.valid = post_valid;
			wdata.tokens = rt;
			wdata.last = new_last;
		end else if (cmd.charge_upd) begin
			wr = 1'b1;
			wdata.tokens = (rt >= {18'd0, win_q}) ? rt - {18'd0, win_q} : rt;
			wdata.last = new_last;
		end else if (cmd.insert) begin
			wr = 1'b1;
			wdata.valid = 1'b1;
			wdata.key = key_q;
			wdata.tokens = (cap_q >= {18'd0, win_q}) ? cap_q - {18'd0, win_q} : cap_q;
			wdata.last = now_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[addr_q] <= wdata;
		end
		if (cmd.rd) begin
			rd_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			opcode_q <= opcode;
			bypass_q <= (rate == 16'd0) || !source_present;
			key_q <= source_key;
			now_q <= now_ms;
			win_q <= eff_win;
			cap_q <= {17'd0, capacity} * {18'd0, eff_win};
		end
		if (cmd.mul) begin
			gt_q <= now_q > rd_q.last;
			prod_q <= (now_q - rd_q.last) * rate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			slot_q <= '0;
			free_q <= '0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			sweep_mode_q <= 1'b0;
			count_q <= '0;
			last_sweep_q <= '0;
			done <= 1'b0;
			reject <= 1'b0;
			outcome <= pstbl_pkg::OUT_BYPASS;
			tracked_count <= '0;
		end else begin
			done <= 1'b0;
			if (cmd.addr_clr) begin
				addr_q <= '0;
			end else if (cmd.addr_inc) begin
				addr_q <= addr_q + 1'b1;
			end else if (cmd.addr_slot) begin
				addr_q <= found_q ? slot_q : free_q;
			end
			if (cmd.scan_clr) begin
				found_q <= 1'b0;
				free_found_q <= 1'b0;
				sweep_mode_q <= cmd.sweep;
				if (cmd.sweep) begin
					last_sweep_q <= now_q;
				end
			end
			if (cmd.scan_upd) begin
				if (freed) begin
					count_q <= count_q - 1'b1;
				end
				if (post_valid && rd_q.key == key_q && !found_q) begin
					found_q <= 1'b1;
					slot_q <= addr_q;
				end
				if (!post_valid && !free_found_q) begin
					free_found_q <= 1'b1;
					free_q <= addr_q;
				end
			end
			if (cmd.charge_upd) begin
				done <= 1'b1;
				reject <= rt < {18'd0, win_q};
				outcome <= (rt >= {18'd0, win_q}) ? pstbl_pkg::OUT_CHARGED
					: pstbl_pkg::OUT_REJECTED;
				tracked_count <= count_q;
			end
			if (cmd.insert) begin
				count_q <= count_q + 1'b1;
				done <= 1'b1;
				reject <= cap_q < {18'd0, win_q};
				outcome <= (cap_q >= {18'd0, win_q}) ? pstbl_pkg::OUT_CHARGED
					: pstbl_pkg::OUT_REJECTED;
				tracked_count <= count_q + 1'b1;
			end
			if (cmd.res_bypass || cmd.res_full) begin
				done <= 1'b1;
				reject <= 1'b0;
				outcome <= cmd.res_full ? pstbl_pkg::OUT_UNTRACKED : pstbl_pkg::OUT_BYPASS;
				tracked_count <= count_q;
			end
		end
	end

	always_comb begin
		sts.opcode = opcode_q;
		sts.bypass = bypass_q;
		sts.due = (now_q >= last_sweep_q) && ((now_q - last_sweep_q) >= {16'd0, interval});
		sts.last = addr_q == pstbl_pkg::IDX_W'(pstbl_pkg::TABLE_ENTRIES - 1);
		sts.found = found_q;
		sts.full = count_q >= pstbl_pkg::CNT_W'(pstbl_pkg::TABLE_ENTRIES);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pstbl_pkg::CNT_W'(pstbl_pkg::TABLE_ENTRIES))
		else $error("tracked count above table size");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == $past(count_q) || count_q == $past(count_q) + 1'b1
		|| count_q == $past(count_q) - 1'b1)
		else $error("tracked count jumped");
	a_reject_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (reject == (outcome == pstbl_pkg::OUT_REJECTED)))
		else $error("reject and outcome disagree");

endmodule

>>> rtl/core/pstbl_ctrl.sv
module pstbl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  pstbl_pkg::sts_t       sts,
	output pstbl_pkg::cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DECIDE, S_SCAN_RD, S_SCAN_MUL, S_SCAN_UPD, S_AFTER,
		S_INS, S_CH_RD, S_CH_MUL, S_CH_UPD
	} state_t;

	typedef enum logic [1:0] {K_SWEEP_CMD, K_REQ, K_FORCED} kind_t;

	state_t state_q, state_d;
	kind_t kind_q, kind_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		kind_d = kind_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				cmd.addr_inc = 1'b1;
				if (sts.last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.opcode) begin
					cmd.addr_clr = 1'b1;
					cmd.scan_clr = 1'b1;
					cmd.sweep = 1'b1;
					kind_d = K_SWEEP_CMD;
					state_d = S_SCAN_RD;
				end else if (sts.bypass) begin
					cmd.res_bypass = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.addr_clr = 1'b1;
					cmd.scan_clr = 1'b1;
					cmd.sweep = sts.due;
					kind_d = K_REQ;
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				cmd.rd = 1'b1;
				state_d = S_SCAN_MUL;
			end
			S_SCAN_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SCAN_UPD;
			end
			S_SCAN_UPD: begin
				cmd.scan_upd = 1'b1;
				cmd.addr_inc = 1'b1;
				state_d = sts.last ? S_AFTER : S_SCAN_RD;
			end
			S_AFTER: begin
				case (kind_q)
					K_SWEEP_CMD: begin
						cmd.res_bypass = 1'b1;
						state_d = S_IDLE;
					end
					K_REQ: begin
						if (sts.found) begin
							cmd.addr_slot = 1'b1;
							state_d = S_CH_RD;
						end else if (sts.full) begin
							// table full: forced sweep before giving up
							cmd.addr_clr = 1'b1;
							cmd.scan_clr = 1'b1;
							cmd.sweep = 1'b1;
							kind_d = K_FORCED;
							state_d = S_SCAN_RD;
						end else begin
							cmd.addr_slot = 1'b1;
							state_d = S_INS;
						end
					end
					default: begin
						if (sts.full) begin
							cmd.res_full = 1'b1;
							state_d = S_IDLE;
						end else begin
							cmd.addr_slot = 1'b1;
							state_d = S_INS;
						end
					end
				endcase
			end
			S_INS: begin
				cmd.insert = 1'b1;
				state_d = S_IDLE;
			end
			S_CH_RD: begin
				cmd.rd = 1'b1;
				state_d = S_CH_MUL;
			end
			S_CH_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CH_UPD;
			end
			S_CH_UPD: begin
				cmd.charge_upd = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			kind_q <= K_REQ;
			busy <= 1'b1;
		end else begin
			state_q <= state_d;
			kind_q <= kind_d;
			busy <= state_d != S_IDLE;
		end
	end

	a_busy_match: assert property (@(posedge clk) disable iff (!arst_n)
		busy == (state_q != S_IDLE))
		else $error("busy out of step with state");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.charge_upd, cmd.insert, cmd.res_bypass, cmd.res_full}))
		else $error("more than one result at once");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy)
		else $error("accepted item without going busy");

endmodule

>>> rtl/core/per_source_token_bucket_limiter.sv
// Per-source token bucket limiter. After reset the block is busy while it clears
// the table. An item is taken when start is high and busy low; its single result
// appears on reject, outcome and tracked_count for exactly one cycle with done
// high, and the receiver cannot stall it. A request that is not bypassed, or a
// sweep, walks the single-port table, reading, multiplying and updating each entry
// in turn; a full table can force a second sweep. Registers are to be written over
// the APB port only while idle, by the user; the block itself does not enforce it.
module per_source_token_bucket_limiter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic        source_present,
	input  logic [31:0] source_key,
	input  logic [31:0] now_ms,
	output logic        done,
	output logic        reject,
	output logic [1:0]  outcome,
	output logic [10:0] tracked_count
);

	logic [15:0] rate_q, window_q, interval_q;
	logic [16:0] capacity_q;
	pstbl_pkg::cmd_t cmd;
	pstbl_pkg::sts_t sts;
	pstbl_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign idx = pstbl_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= '0;
			window_q <= 16'd1000;
			capacity_q <= '0;
			interval_q <= 16'd1000;
		end else if (psel && penable && pwrite) begin
			case (idx)
				pstbl_pkg::REG_RATE:     rate_q <= pwdata[15:0];
				pstbl_pkg::REG_WINDOW:   window_q <= pwdata[15:0];
				pstbl_pkg::REG_CAPACITY: capacity_q <= pwdata[16:0];
				pstbl_pkg::REG_INTERVAL: interval_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			pstbl_pkg::REG_RATE:     prdata = {16'd0, rate_q};
			pstbl_pkg::REG_WINDOW:   prdata = {16'd0, window_q};
			pstbl_pkg::REG_CAPACITY: prdata = {15'd0, capacity_q};
			pstbl_pkg::REG_INTERVAL: prdata = {16'd0, interval_q};
			default:                 prdata = '0;
		endcase
	end

	pstbl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	pstbl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (opcode),
		.source_present (source_present),
		.source_key     (source_key),
		.now_ms         (now_ms),
		.rate           (rate_q),
		.window         (window_q),
		.capacity       (capacity_q),
		.interval       (interval_q),
		.done           (done),
		.reject         (reject),
		.outcome        (outcome),
		.tracked_count  (tracked_count)
	);

endmodule

>>> verif/per_source_token_bucket_limiter_tb.sv
`timescale 1ns / 1ps

module per_source_token_bucket_limiter_tb;

	typedef struct {
		logic                  reject;
		pstbl_pkg::outcome_t   outcome;
		logic [10:0]           tracked;
	} verdict_t;

	typedef struct {
		bit                    is_cfg;
		pstbl_pkg::reg_idx_t   idx;
		logic [31:0]           val;
		bit                    op;
		bit                    pres;
		logic [31:0]           key;
		logic [31:0]           now;
		bit                    typed;
		verdict_t              want;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 0;
	logic        busy;
	logic        opcode = 0, source_present = 0;
	logic [31:0] source_key = '0, now_ms = '0;
	logic        done;
	logic        reject;
	logic [1:0]  outcome;
	logic [10:0] tracked_count;

	per_source_token_bucket_limiter i_dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// own copy of the limiter state
	bit [15:0]  rate_r, window_r, interval_r;
	bit [16:0]  capacity_r;
	bit         slot_used [pstbl_pkg::TABLE_ENTRIES];
	bit [31:0]  slot_key [pstbl_pkg::TABLE_ENTRIES];
	bit [33:0]  slot_tokens [pstbl_pkg::TABLE_ENTRIES];
	bit [31:0]  slot_stamp [pstbl_pkg::TABLE_ENTRIES];
	bit [31:0]  swept_at;
	int         live_slots;

	verdict_t   pending_q[$];
	int         mismatches;
	int         send_idle_pct;
	bit [31:0]  clock_ms;

	function automatic longint unsigned scale_units();
		return (window_r != 0) ? window_r : 1000;
	endfunction

	function automatic bit [33:0] full_units();
		longint unsigned p;
		p = capacity_r * scale_units();
		return p[33:0];
	endfunction

	function automatic void top_up(int i, bit [31:0] t);
		longint unsigned sum;
		bit [31:0] gap;
		if (t <= slot_stamp[i])
			return;
		gap = t - slot_stamp[i];
		sum = slot_tokens[i] + longint'(gap) * rate_r;
		if (sum > full_units())
			sum = full_units();
		slot_tokens[i] = sum[33:0];
		slot_stamp[i] = t;
	endfunction

	function automatic void sweep_buckets(bit [31:0] t);
		for (int i = 0; i < pstbl_pkg::TABLE_ENTRIES; i++) begin
			if (slot_used[i]) begin
				top_up(i, t);
				if (slot_tokens[i] >= full_units()) begin
					slot_used[i] = 0;
					live_slots--;
				end
			end
		end
		swept_at = t;
	endfunction

	function automatic verdict_t limiter_predict(bit op, bit pres, bit [31:0] key,
		bit [31:0] t);
		verdict_t v;
		int slot;
		bit hit;
		v.reject = 0;
		v.outcome = pstbl_pkg::OUT_BYPASS;
		slot = 0;
		hit = 0;
		if (op) begin
			sweep_buckets(t);
		end else if (rate_r != 0 && pres) begin
			if (t >= swept_at && (t - swept_at) >= interval_r)
				sweep_buckets(t);
			for (int i = 0; i < pstbl_pkg::TABLE_ENTRIES && !hit; i++) begin
				if (slot_used[i] && slot_key[i] == key) begin
					slot = i;
					hit = 1;
				end
			end
			if (hit) begin
				top_up(slot, t);
			end else begin
				if (live_slots >= pstbl_pkg::TABLE_ENTRIES)
					sweep_buckets(t);
				if (live_slots >= pstbl_pkg::TABLE_ENTRIES) begin
					v.outcome = pstbl_pkg::OUT_UNTRACKED;
				end else begin
					for (int i = pstbl_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
						if (!slot_used[i])
							slot = i;
					slot_used[slot] = 1;
					slot_key[slot] = key;
					slot_tokens[slot] = full_units();
					slot_stamp[slot] = t;
					live_slots++;
					hit = 1;
				end
			end
			if (hit) begin
				if (slot_tokens[slot] >= scale_units()) begin
					slot_tokens[slot] -= scale_units();
					v.outcome = pstbl_pkg::OUT_CHARGED;
				end else begin
					v.reject = 1;
					v.outcome = pstbl_pkg::OUT_REJECTED;
				end
			end
		end
		v.tracked = 11'(live_slots);
		return v;
	endfunction

	// registers only change with the table idle
	task automatic reg_write(pstbl_pkg::reg_idx_t idx, logic [31:0] val);
		wait (pending_q.size() == 0);
		repeat (12) @(negedge clk);
		psel = 1;
		pwrite = 1;
		penable = 0;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
		case (idx)
			pstbl_pkg::REG_RATE:     rate_r = val[15:0];
			pstbl_pkg::REG_WINDOW:   window_r = val[15:0];
			pstbl_pkg::REG_CAPACITY: capacity_r = val[16:0];
			default:                 interval_r = val[15:0];
		endcase
	endtask

	task automatic send_request(bit op, bit pres, logic [31:0] key, logic [31:0] t,
		bit typed = 0, verdict_t want = '{1'b0, pstbl_pkg::OUT_CHARGED, 11'd0});
		verdict_t v;
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		opcode = op;
		source_present = pres;
		source_key = key;
		now_ms = t;
		start = 1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		v = limiter_predict(op, pres, key, t);
		pending_q.push_back(typed ? want : v);
		@(negedge clk);
		start = 0;
	endtask

	always @(posedge clk) begin
		verdict_t w;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: reject %0d outcome %0d count %0d",
						reject, outcome, tracked_count);
			end else begin
				w = pending_q.pop_front();
				if (reject !== w.reject || outcome !== w.outcome
						|| tracked_count !== w.tracked) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
							w.reject, w.outcome, w.tracked,
							reject, outcome, tracked_count);
				end
			end
		end
	end

	function automatic row_t blank_row();
		row_t r;
		r.is_cfg = 0;
		r.idx = pstbl_pkg::REG_RATE;
		r.val = '0;
		r.op = 0;
		r.pres = 0;
		r.key = '0;
		r.now = '0;
		r.typed = 0;
		r.want = '{1'b0, pstbl_pkg::OUT_CHARGED, 11'd0};
		return r;
	endfunction

	function automatic row_t item_row(bit op, bit pres, logic [31:0] key,
		logic [31:0] t);
		row_t r;
		r = blank_row();
		r.op = op;
		r.pres = pres;
		r.key = key;
		r.now = t;
		return r;
	endfunction

	function automatic row_t typed_row(bit op, bit pres, logic [31:0] key,
		logic [31:0] t, logic rej, pstbl_pkg::outcome_t oc, logic [10:0] cnt);
		row_t r;
		r = item_row(op, pres, key, t);
		r.typed = 1;
		r.want = '{rej, oc, cnt};
		return r;
	endfunction

	function automatic row_t cfg_row(pstbl_pkg::reg_idx_t idx, logic [31:0] val);
		row_t r;
		r = blank_row();
		r.is_cfg = 1;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic logic [31:0] pick_reg(pstbl_pkg::reg_idx_t idx);
		logic [31:0] hi;
		hi = (idx == pstbl_pkg::REG_CAPACITY) ? 131070 : 65535;
		case ($urandom_range(5))
			0: return (idx == pstbl_pkg::REG_RATE || idx == pstbl_pkg::REG_CAPACITY) ? 0 : 1;
			1: return hi;
			2: return $urandom_range(1, 4);
			default: return $urandom_range(1, 3000);
		endcase
	endfunction

	initial begin
		#400_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		row_t rows[$];
		logic [31:0] keys[16];
		logic [31:0] k;
		int n;
		rate_r = 0;
		window_r = 1000;
		capacity_r = 0;
		interval_r = 1000;
		swept_at = 0;
		live_slots = 0;
		mismatches = 0;
		send_idle_pct = 0;
		foreach (slot_used[i]) slot_used[i] = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		rows.push_back(typed_row(0, 1, 32'h0, 32'h0, 0, pstbl_pkg::OUT_BYPASS, 0));
		rows.push_back(cfg_row(pstbl_pkg::REG_RATE, 1));
		rows.push_back(cfg_row(pstbl_pkg::REG_WINDOW, 0));
		rows.push_back(cfg_row(pstbl_pkg::REG_CAPACITY, 2));
		rows.push_back(cfg_row(pstbl_pkg::REG_INTERVAL, 0));
		rows.push_back(typed_row(0, 0, 32'hFFFF_FFFF, 5, 0, pstbl_pkg::OUT_BYPASS, 0));
		rows.push_back(typed_row(0, 1, 32'h0, 10, 0, pstbl_pkg::OUT_CHARGED, 1));
		rows.push_back(typed_row(0, 1, 32'h0, 10, 0, pstbl_pkg::OUT_CHARGED, 1));
		rows.push_back(typed_row(0, 1, 32'h0, 10, 1, pstbl_pkg::OUT_REJECTED, 1));
		rows.push_back(item_row(0, 1, 32'hFFFF_FFFF, 11));
		rows.push_back(item_row(1, 0, 32'h0, 20));
		// time running backwards
		rows.push_back(item_row(0, 1, 32'h0, 3));
		rows.push_back(item_row(0, 1, 32'hFFFF_FFFF, 2500));
		rows.push_back(cfg_row(pstbl_pkg::REG_RATE, 65535));
		rows.push_back(cfg_row(pstbl_pkg::REG_WINDOW, 65535));
		rows.push_back(cfg_row(pstbl_pkg::REG_CAPACITY, 131070));
		rows.push_back(cfg_row(pstbl_pkg::REG_INTERVAL, 65535));
		rows.push_back(item_row(0, 1, 32'h1234_5678, 32'hFFFF_FFFF));
		rows.push_back(item_row(0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		rows.push_back(cfg_row(pstbl_pkg::REG_WINDOW, 1));
		rows.push_back(cfg_row(pstbl_pkg::REG_CAPACITY, 0));
		rows.push_back(item_row(0, 1, 32'hA5A5_5A5A, 32'hFFFF_FFFF));
		rows.push_back(item_row(0, 1, 32'h1234_5678, 32'hFFFF_FFFF));
		rows.push_back(cfg_row(pstbl_pkg::REG_CAPACITY, 1));
		rows.push_back(item_row(0, 1, 32'h5A5A_A5A5, 32'hFFFF_FFFF));
		rows.push_back(item_row(1, 1, 32'h0, 32'h0));
		rows.push_back(item_row(0, 1, 32'h0, 32'h0));
		foreach (rows[i]) begin
			if (rows[i].is_cfg)
				reg_write(rows[i].idx, rows[i].val);
			else
				send_request(rows[i].op, rows[i].pres, rows[i].key, rows[i].now,
					rows[i].typed, rows[i].want);
		end

		// fill the table, then overflow it with no bucket able to refill
		reg_write(pstbl_pkg::REG_RATE, 1);
		reg_write(pstbl_pkg::REG_WINDOW, 1000);
		reg_write(pstbl_pkg::REG_CAPACITY, 1);
		reg_write(pstbl_pkg::REG_INTERVAL, 65535);
		send_request(1, 1, 32'h0, 100000);
		n = 0;
		while (live_slots < pstbl_pkg::TABLE_ENTRIES) begin
			send_request(0, 1, 32'h1000_0000 + n, 100000);
			n++;
		end
		send_request(0, 1, 32'h2000_0000, 100000);
		// buckets refill to full, so the forced sweep frees the table
		send_request(0, 1, 32'h2000_0001, 101000);
		// hold off until the table has drained
		wait (pending_q.size() == 0);
		clock_ms = 101000;

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 1) ? 67 : (phase == 0) ? 6 : 0;
			reg_write(pstbl_pkg::REG_RATE,
				pick_reg(pstbl_pkg::REG_RATE) | (phase == 2 ? 1 : 0));
			reg_write(pstbl_pkg::REG_WINDOW, pick_reg(pstbl_pkg::REG_WINDOW));
			reg_write(pstbl_pkg::REG_CAPACITY, pick_reg(pstbl_pkg::REG_CAPACITY));
			reg_write(pstbl_pkg::REG_INTERVAL, pick_reg(pstbl_pkg::REG_INTERVAL));
			foreach (keys[i]) keys[i] = $urandom;
			for (int j = 0; j < 210; j++) begin
				case ($urandom_range(19))
					0: clock_ms -= $urandom_range(50);
					1: clock_ms += $urandom_range(70000);
					default: clock_ms += $urandom_range(600);
				endcase
				k = ($urandom_range(9) == 0) ? $urandom : keys[$urandom_range(15)];
				send_request($urandom_range(19) == 0, $urandom_range(19) != 0, k,
					clock_ms);
			end
		end

		wait (pending_q.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
rtl/core/pstbl_pkg.sv
rtl/core/pstbl_dp.sv
rtl/core/pstbl_ctrl.sv
rtl/core/per_source_token_bucket_limiter.sv
verif/per_source_token_bucket_limiter_tb.sv
